FILE: hw/rtl/maft_pkg.sv
// ----------------------------------------------------------------------------
// maft_pkg: shared types and constants for the masked address filter table
// Holds the request and status codes and the controller/datapath links.
// ----------------------------------------------------------------------------
package maft_pkg;

	// default number of table entries
	localparam int unsigned TABLE_DEPTH_DEF = 1024;

	// field widths fixed by the interface
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned SLOT_W   = 10;
	localparam int unsigned STATUS_W = 2;

	// request modes
	localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;    // latch a new request, restart the scan
		logic step;    // advance the scan by one entry
		logic commit;  // update the table and load the result register
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic done;    // scan has found its entry or reached the high-water mark
	} dp_stat_t;

endpackage

FILE: hw/rtl/maft_ctrl.sv
// ----------------------------------------------------------------------------
// maft_ctrl: request sequencer
// Accepts requests, steps the table scan and hands results to the output
// register, holding the finished scan while that register is still full.
// ----------------------------------------------------------------------------
module maft_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output maft_pkg::ctl_cmd_t  cmd,
	input  maft_pkg::dp_stat_t  stat
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// issue commands from the current state
	always_comb begin
		cmd.load   = in_valid && (state_q == S_IDLE);
		cmd.step   = (state_q == S_SCAN) && !stat.done;
		cmd.commit = (state_q == S_SCAN) && stat.done && (!out_valid_q || out_ready);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.load) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (cmd.commit) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the result flag until the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// an accepted request always starts a scan
	a_load_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_SCAN))
		else $error("accepted request did not start a scan");

	// the scan never advances past its own result
	a_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !stat.done)
		else $error("scan stepped after finishing");
`endif

endmodule

FILE: hw/rtl/maft_dp.sv
// ----------------------------------------------------------------------------
// maft_dp: filter table datapath
// Holds the entry memories, the high-water mark, the scan pointer and the
// compare logic, and builds each result in the output register.
// ----------------------------------------------------------------------------
module maft_dp #(
	parameter int unsigned TABLE_DEPTH = maft_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  maft_pkg::ctl_cmd_t                   cmd,
	output maft_pkg::dp_stat_t                   stat,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_data,
	input  logic [maft_pkg::MODE_W-1:0]          mode,
	input  logic [maft_pkg::ADDR_W-1:0]          address,
	input  logic [maft_pkg::ADDR_W-1:0]          entry_mask,
	input  logic [maft_pkg::ADDR_W-1:0]          entry_value,
	output logic                                 reject,
	output logic                                 matched,
	output logic [maft_pkg::SLOT_W-1:0]          slot,
	output logic [maft_pkg::STATUS_W-1:0]        status
);

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned AW    = maft_pkg::ADDR_W;

	// table storage: mask and value share a word, valid flags apart
	logic [2*AW-1:0] entry_mem [TABLE_DEPTH];
	logic            valid_mem [TABLE_DEPTH];

	logic                        ban_q;
	logic [CNT_W-1:0]            hw_q;
	logic [CNT_W-1:0]            rd_ptr_q;
	logic [maft_pkg::MODE_W-1:0] mode_q;
	logic [AW-1:0]               addr_q;
	logic [AW-1:0]               emask_q;
	logic [AW-1:0]               evalue_q;

	logic                        pend_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic [2*AW-1:0]             rd_entry_s1;
	logic                        rd_vld_s1;

	logic                        rd_en;
	logic                        hit;
	logic [AW-1:0]               rd_mask;
	logic [AW-1:0]               rd_value;
	logic                        full;

	logic                        entry_we;
	logic                        valid_we;
	logic                        valid_wdata;
	logic [IDX_W-1:0]            wr_idx;
	logic                        hw_inc;

	logic                        reject_q;
	logic                        matched_q;
	logic [maft_pkg::SLOT_W-1:0] slot_q;
	logic [maft_pkg::STATUS_W-1:0] status_q;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ban_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			ban_q <= cfg_data;
		end
	end

	// latch the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			addr_q   <= address;
			emask_q  <= entry_mask;
			evalue_q <= entry_value;
		end
	end

	// scan pointer and read stage
	assign rd_en = cmd.step && (rd_ptr_q < hw_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			pend_s1  <= 1'b0;
		end else if (cmd.load) begin
			rd_ptr_q <= '0;
			pend_s1  <= 1'b0;
		end else if (cmd.step) begin
			pend_s1 <= rd_en;
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry_s1 <= entry_mem[rd_ptr_q[IDX_W-1:0]];
			rd_vld_s1   <= valid_mem[rd_ptr_q[IDX_W-1:0]];
			idx_s1      <= rd_ptr_q[IDX_W-1:0];
		end
	end

	// compare the entry just read against the request
	assign rd_mask  = rd_entry_s1[2*AW-1:AW];
	assign rd_value = rd_entry_s1[AW-1:0];

	always_comb begin
		priority if (mode_q == maft_pkg::MODE_CHECK) begin
			hit = rd_vld_s1 && ((addr_q & rd_mask) == rd_value);
		end else if (mode_q == maft_pkg::MODE_ADD) begin
			hit = !rd_vld_s1;
		end else if (mode_q == maft_pkg::MODE_REMOVE) begin
			hit = rd_vld_s1 && (rd_mask == emask_q) && (rd_value == evalue_q);
		end else begin
			hit = 1'b0;
		end
	end

	assign stat.done = pend_s1 ? hit : (rd_ptr_q == hw_q);
	assign full      = (hw_q == CNT_W'(TABLE_DEPTH));

	// table updates at commit
	always_comb begin
		entry_we    = 1'b0;
		valid_we    = 1'b0;
		valid_wdata = 1'b0;
		wr_idx      = idx_s1;
		hw_inc      = 1'b0;
		if (cmd.commit) begin
			if (mode_q == maft_pkg::MODE_ADD) begin
				if (pend_s1) begin
					entry_we    = 1'b1;
					valid_we    = 1'b1;
					valid_wdata = 1'b1;
				end else if (!full) begin
					entry_we    = 1'b1;
					valid_we    = 1'b1;
					valid_wdata = 1'b1;
					wr_idx      = hw_q[IDX_W-1:0];
					hw_inc      = 1'b1;
				end
			end else if (mode_q == maft_pkg::MODE_REMOVE) begin
				valid_we = pend_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (entry_we) begin
			entry_mem[wr_idx] <= {emask_q, evalue_q};
		end
	end

	always_ff @(posedge clk) begin
		if (valid_we) begin
			valid_mem[wr_idx] <= valid_wdata;
		end
	end

	// advance the high-water mark on append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= '0;
		end else if (hw_inc) begin
			hw_q <= hw_q + 1'b1;
		end
	end

	// build the result
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			reject_q  <= 1'b0;
			matched_q <= 1'b0;
			slot_q    <= '0;
			status_q  <= maft_pkg::ST_DONE;
			priority if (mode_q == maft_pkg::MODE_CHECK) begin
				reject_q  <= pend_s1 ? ban_q : !ban_q;
				matched_q <= pend_s1;
				if (pend_s1) begin
					slot_q <= maft_pkg::SLOT_W'(idx_s1);
				end
			end else if (mode_q == maft_pkg::MODE_ADD) begin
				if (pend_s1) begin
					slot_q <= maft_pkg::SLOT_W'(idx_s1);
				end else if (full) begin
					status_q <= maft_pkg::ST_FULL;
				end else begin
					slot_q <= maft_pkg::SLOT_W'(hw_q);
				end
			end else if (mode_q == maft_pkg::MODE_REMOVE) begin
				matched_q <= pend_s1;
				if (pend_s1) begin
					slot_q <= maft_pkg::SLOT_W'(idx_s1);
				end else begin
					status_q <= maft_pkg::ST_MISSING;
				end
			end
		end
	end

	assign reject  = reject_q;
	assign matched = matched_q;
	assign slot    = slot_q;
	assign status  = status_q;

`ifndef NO_ASSERTIONS
	// the high-water mark never passes the table size
	a_hw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= CNT_W'(TABLE_DEPTH))
		else $error("high-water mark beyond table");

	// the scan pointer stays within the used part of the table
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ptr_q <= hw_q)
		else $error("scan pointer beyond high-water mark");

	// a new request starts with an empty read stage
	a_load_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (!pend_s1 && (rd_ptr_q == '0)))
		else $error("scan not restarted on load");
`endif

endmodule

FILE: hw/rtl/masked_address_filter_table_core.sv
// ----------------------------------------------------------------------------
// masked_address_filter_table_core: masked IPv4 address filter table
// Checks addresses against a table of mask/value entries and adds or frees
// entries on request.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    mode, address, entry_mask, entry_value
//  out      output     out_valid / out_ready  reject, matched, slot, status
//  cfg      input      cfg_valid / cfg_ready  cfg_data (ban_on_match)
//
//  The scan reads one entry per cycle from the table memory, stopping at the first
//  hit or at the high-water mark, so it reads at most TABLE_DEPTH entries (1024 by
//  default).
//  One request is in progress at a time; the next is taken in the cycle after
//  the previous result has been loaded into the output register.
//  A finished scan waits while the output register is still full.
//  Reset empties the table by clearing the high-water mark; no clearing pass.
// ----------------------------------------------------------------------------
module masked_address_filter_table_core #(
	parameter int unsigned TABLE_DEPTH = maft_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [maft_pkg::MODE_W-1:0]     mode,
	input  logic [maft_pkg::ADDR_W-1:0]     address,
	input  logic [maft_pkg::ADDR_W-1:0]     entry_mask,
	input  logic [maft_pkg::ADDR_W-1:0]     entry_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            reject,
	output logic                            matched,
	output logic [maft_pkg::SLOT_W-1:0]     slot,
	output logic [maft_pkg::STATUS_W-1:0]   status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_data
);

	maft_pkg::ctl_cmd_t cmd;
	maft_pkg::dp_stat_t stat;

	// sequencer
	maft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// table and compare datapath
	maft_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mode        (mode),
		.address     (address),
		.entry_mask  (entry_mask),
		.entry_value (entry_value),
		.reject      (reject),
		.matched     (matched),
		.slot        (slot),
		.status      (status)
	);

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: request and result checking for masked_address_filter_table_core
// Sends a short directed sequence, then random check, add and remove requests
// under both ban settings. Then it empties the table, refills a few exact
// entries and probes them. Every result is compared field by field with the
// outcome given in its directed row or worked out by a shadow copy of the table.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH              = maft_pkg::TABLE_DEPTH_DEF;
	localparam logic [maft_pkg::MODE_W-1:0] MODE_IGNORED = 2'd3;
	localparam int unsigned RANDOM_PHASE_ITEMS = 118;
	localparam int unsigned WATCHDOG_LIMIT     = 6000;
	localparam int unsigned TAIL_CYCLES        = 1100;
	localparam logic [maft_pkg::ADDR_W-1:0] FILL_BASE = 32'hC0A8_0000;
	localparam int unsigned FILL_COUNT         = 16;
	localparam int unsigned DIRECTED_COUNT     = 24;

	typedef struct packed {
		logic                          reject;
		logic                          matched;
		logic [maft_pkg::SLOT_W-1:0]   slot;
		logic [maft_pkg::STATUS_W-1:0] status;
	} filter_outcome_t;

	typedef struct packed {
		logic [maft_pkg::MODE_W-1:0] mode;
		logic [maft_pkg::ADDR_W-1:0] address;
		logic [maft_pkg::ADDR_W-1:0] mask;
		logic [maft_pkg::ADDR_W-1:0] value;
		logic                        typed;
		filter_outcome_t             outcome;
	} directed_row_t;

	// ban mode is still at its reset value (1) throughout these rows
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// empty table: nothing matches, nothing to remove, mode 3 ignored
		'{maft_pkg::MODE_CHECK, 32'h00000000, 32'h0, 32'h0, 1,
			'{0, 0, 0, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_CHECK, 32'hFFFFFFFF, 32'h0, 32'h0, 1,
			'{0, 0, 0, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_REMOVE, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1,
			'{0, 0, 0, maft_pkg::ST_MISSING}},
		'{MODE_IGNORED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1,
			'{0, 0, 0, maft_pkg::ST_DONE}},
		// append three entries, the last with value bits outside its mask
		'{maft_pkg::MODE_ADD, 32'hFFFFFFFF, 32'h00FFFFFF, 32'h0001A8C0, 1,
			'{0, 0, 0, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_ADD, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1,
			'{0, 0, 1, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_ADD, 32'h0, 32'h000000FF, 32'h000001FF, 1,
			'{0, 0, 2, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_CHECK, 32'h7B01A8C0, 32'h0, 32'h0, 1,
			'{1, 1, 0, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_CHECK, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 1,
			'{1, 1, 1, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_CHECK, 32'h000001FF, 32'h0, 32'h0, 1,
			'{0, 0, 0, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_REMOVE, 32'h0, 32'h000000FF, 32'h000001FF, 1,
			'{0, 1, 2, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_REMOVE, 32'h0, 32'h000000FF, 32'h000001FF, 1,
			'{0, 0, 0, maft_pkg::ST_MISSING}},
		// duplicate add reuses the freed slot, remove takes the lowest copy
		'{maft_pkg::MODE_ADD, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1,
			'{0, 0, 2, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_REMOVE, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1,
			'{0, 1, 1, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_CHECK, 32'hFFFFFFFF, 32'h0, 32'h0, 1,
			'{1, 1, 2, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_REMOVE, 32'h0, 32'h00FFFFFF, 32'h0001A8C0, 1,
			'{0, 1, 0, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_CHECK, 32'h7B01A8C0, 32'h0, 32'h0, 1,
			'{0, 0, 0, maft_pkg::ST_DONE}},
		// match-all entry in slot 0, then an octet-0 entry in slot 1
		'{maft_pkg::MODE_ADD, 32'h0, 32'h00000000, 32'h00000000, 1,
			'{0, 0, 0, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_CHECK, 32'h00000000, 32'h0, 32'h0, 1,
			'{1, 1, 0, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_ADD, 32'h0, 32'hFF000000, 32'hAB000000, 1,
			'{0, 0, 1, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_REMOVE, 32'h0, 32'h00000000, 32'h00000000, 1,
			'{0, 1, 0, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_CHECK, 32'hAB123456, 32'h0, 32'h0, 0,
			'{0, 0, 0, maft_pkg::ST_DONE}},
		'{MODE_IGNORED, 32'h12345678, 32'hFF000000, 32'hAB000000, 0,
			'{0, 0, 0, maft_pkg::ST_DONE}},
		'{maft_pkg::MODE_ADD, 32'h5A5A5A5A, 32'hFFFFFFFF, 32'hC0A80001, 0,
			'{0, 0, 0, maft_pkg::ST_DONE}}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [maft_pkg::MODE_W-1:0]   mode;
	logic [maft_pkg::ADDR_W-1:0]   address;
	logic [maft_pkg::ADDR_W-1:0]   entry_mask;
	logic [maft_pkg::ADDR_W-1:0]   entry_value;
	logic                          out_valid;
	logic                          out_ready;
	logic                          reject;
	logic                          matched;
	logic [maft_pkg::SLOT_W-1:0]   slot;
	logic [maft_pkg::STATUS_W-1:0] status;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic                          cfg_data;

	// shadow copy of the filter table
	logic [maft_pkg::ADDR_W-1:0] shadow_mask [DEPTH];
	logic [maft_pkg::ADDR_W-1:0] shadow_value [DEPTH];
	bit                          shadow_live [DEPTH];
	int unsigned                 shadow_high = 0;
	int unsigned                 live_count  = 0;
	bit                          shadow_ban  = 1'b1;

	filter_outcome_t             awaited_outcomes [$];
	filter_outcome_t             head_outcome;
	int unsigned                 error_count = 0;
	int unsigned                 idle_cycles = 0;
	int unsigned                 burst_left  = 0;
	int unsigned                 ready_roll;
	int unsigned                 pick_idx;
	int unsigned                 fill_tag;
	logic [maft_pkg::ADDR_W-1:0] last_fill;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	masked_address_filter_table_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.address     (address),
		.entry_mask  (entry_mask),
		.entry_value (entry_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.reject      (reject),
		.matched     (matched),
		.slot        (slot),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// Work out the outcome of one request and update the shadow table
	function automatic filter_outcome_t filter_outcome(
			input logic [maft_pkg::MODE_W-1:0] req_mode,
			input logic [maft_pkg::ADDR_W-1:0] req_addr,
			input logic [maft_pkg::ADDR_W-1:0] req_mask,
			input logic [maft_pkg::ADDR_W-1:0] req_value);
		filter_outcome_t res;
		int unsigned i;
		res = '0;
		case (req_mode)
			maft_pkg::MODE_CHECK: begin
				for (i = 0; i < shadow_high; i++)
					if (shadow_live[i] && (req_addr & shadow_mask[i]) == shadow_value[i])
						break;
				res.matched = (i < shadow_high);
				res.slot    = res.matched ? maft_pkg::SLOT_W'(i) : '0;
				res.reject  = res.matched ? shadow_ban : !shadow_ban;
			end
			maft_pkg::MODE_ADD: begin
				for (i = 0; i < shadow_high; i++)
					if (!shadow_live[i])
						break;
				if (i >= DEPTH) begin
					res.status = maft_pkg::ST_FULL;
				end else begin
					// append when no freed slot lies below the mark
					if (i == shadow_high)
						shadow_high++;
					shadow_mask[i]  = req_mask;
					shadow_value[i] = req_value;
					shadow_live[i]  = 1'b1;
					live_count++;
					res.slot = maft_pkg::SLOT_W'(i);
				end
			end
			maft_pkg::MODE_REMOVE: begin
				for (i = 0; i < shadow_high; i++)
					if (shadow_live[i] && shadow_mask[i] == req_mask &&
							shadow_value[i] == req_value)
						break;
				if (i < shadow_high) begin
					shadow_live[i] = 1'b0;
					live_count--;
					res.matched = 1'b1;
					res.slot    = maft_pkg::SLOT_W'(i);
				end else begin
					res.status = maft_pkg::ST_MISSING;
				end
			end
			default: begin
				// ignored request: all fields stay zero
			end
		endcase
		return res;
	endfunction

	// Gap before a request: mostly none or short, a few long, bursts of none
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if (roll < 4) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	// Pick a live entry of the shadow table, starting from a random slot
	function automatic int unsigned pick_live();
		int unsigned first, k, idx;
		first = $urandom_range(0, shadow_high - 1);
		for (k = 0; k < shadow_high; k++) begin
			idx = (first + k) % shadow_high;
			if (shadow_live[idx])
				return idx;
		end
		return 0;
	endfunction

	// Present one request, hold it until taken, then queue its outcome
	task automatic send_request(input logic [maft_pkg::MODE_W-1:0] req_mode,
			input logic [maft_pkg::ADDR_W-1:0] req_addr,
			input logic [maft_pkg::ADDR_W-1:0] req_mask,
			input logic [maft_pkg::ADDR_W-1:0] req_value, input bit typed,
			input filter_outcome_t typed_outcome);
		int unsigned gap;
		filter_outcome_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= req_mode;
		address     <= req_addr;
		entry_mask  <= req_mask;
		entry_value <= req_value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = filter_outcome(req_mode, req_addr, req_mask, req_value);
		awaited_outcomes.push_back(typed ? typed_outcome : predicted);
	endtask

	// Hold until every queued outcome has been seen
	task automatic settle();
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Write the ban mode register once the block is idle
	task automatic write_ban_mode(input bit ban);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= ban;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid  <= 1'b0;
		shadow_ban = ban;
	endtask

	// Random requests, mostly aimed at live entries, the table kept small
	task automatic run_random_phase(input int unsigned count);
		int unsigned n, roll, idx, add_weight;
		logic [maft_pkg::MODE_W-1:0] req_mode;
		logic [maft_pkg::ADDR_W-1:0] req_addr, req_mask, req_value;
		n = 0;
		while (n < count) begin
			roll       = $urandom_range(0, 99);
			req_addr   = $urandom;
			req_mask   = $urandom;
			req_value  = $urandom;
			add_weight = (live_count < 40) ? 30 : 12;
			if (roll < 4) begin
				req_mode = MODE_IGNORED;
			end else if (roll < 50) begin
				// aim most checks at a live entry, wildcard octets random
				req_mode = maft_pkg::MODE_CHECK;
				if (live_count > 0 && $urandom_range(0, 99) < 65) begin
					idx      = pick_live();
					req_addr = shadow_value[idx] | (req_addr & ~shadow_mask[idx]);
				end
			end else if (roll < 50 + add_weight) begin
				req_mode = maft_pkg::MODE_ADD;
				roll     = $urandom_range(0, 99);
				if (roll < 75) begin
					// well-formed entry: octets exact or wildcard, wildcards zero
					for (int b = 0; b < 4; b++)
						req_mask[8*b +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					req_value = req_value & req_mask;
				end else if (roll < 88 && live_count > 0) begin
					idx       = pick_live();
					req_mask  = shadow_mask[idx];
					req_value = shadow_value[idx];
				end
			end else begin
				req_mode = maft_pkg::MODE_REMOVE;
				roll     = $urandom_range(0, 99);
				if (live_count > 0 && roll < 85) begin
					idx       = pick_live();
					req_mask  = shadow_mask[idx];
					req_value = shadow_value[idx];
					// near miss: one bit off in the mask or the value
					if (roll >= 70) begin
						if ($urandom_range(0, 1))
							req_mask = req_mask ^
								(32'd1 << $urandom_range(0, maft_pkg::ADDR_W - 1));
						else
							req_value = req_value ^
								(32'd1 << $urandom_range(0, maft_pkg::ADDR_W - 1));
					end
				end
			end
			send_request(req_mode, req_addr, req_mask, req_value, 1'b0, '0);
			if (req_mode != MODE_IGNORED)
				n++;
		end
		in_valid <= 1'b0;
	endtask

	// Stimulus and end of run
	initial begin
		in_valid    <= 1'b0;
		mode        <= maft_pkg::MODE_CHECK;
		address     <= '0;
		entry_mask  <= '0;
		entry_value <= '0;
		cfg_valid   <= 1'b0;
		cfg_data    <= 1'b0;
		arst_n      <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows under the reset ban mode
		for (int r = 0; r < DIRECTED_COUNT; r++)
			send_request(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].address,
				DIRECTED_ROWS[r].mask, DIRECTED_ROWS[r].value,
				DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].outcome);
		in_valid <= 1'b0;

		// random phases, alternating allow-list and ban-list
		for (int ph = 0; ph < 4; ph++) begin
			write_ban_mode(ph[0]);
			run_random_phase(RANDOM_PHASE_ITEMS);
		end

		// empty the table, then refill a few exact entries
		write_ban_mode(1'b0);
		while (live_count > 0) begin
			pick_idx = pick_live();
			send_request(maft_pkg::MODE_REMOVE, $urandom, shadow_mask[pick_idx],
				shadow_value[pick_idx], 1'b0, '0);
		end
		fill_tag = 0;
		while (fill_tag < FILL_COUNT) begin
			send_request(maft_pkg::MODE_ADD, $urandom, '1, FILL_BASE | fill_tag, 1'b0, '0);
			fill_tag++;
		end
		last_fill = FILL_BASE | (fill_tag - 1);

		// probe the refilled table: reused slot, hit on the last entry, full-length miss
		send_request(maft_pkg::MODE_ADD, $urandom, $urandom, $urandom, 1'b0, '0);
		send_request(maft_pkg::MODE_CHECK, last_fill, $urandom, $urandom, 1'b0, '0);
		send_request(maft_pkg::MODE_CHECK, 32'h0102_0304, $urandom, $urandom, 1'b0, '0);
		pick_idx = pick_live();
		send_request(maft_pkg::MODE_REMOVE, $urandom, shadow_mask[pick_idx],
			shadow_value[pick_idx], 1'b0, '0);
		send_request(maft_pkg::MODE_ADD, $urandom, '1, 32'h0D0C_0B0A, 1'b0, '0);
		send_request(maft_pkg::MODE_ADD, $urandom, '1, 32'h0D0C_0B0B, 1'b0, '0);
		send_request(maft_pkg::MODE_REMOVE, $urandom, 32'h00FF_00FF, 32'h0012_0034,
			1'b0, '0);
		in_valid <= 1'b0;

		// drain, then watch for stray results
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Result side: random stalls, mostly short, a few long, some long open stretches
	initial begin
		out_ready <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 45) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else if (ready_roll < 53) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(150, 400)) @(posedge clk);
			end else if (ready_roll < 90) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end
		end
	end

	// Compare each accepted result with the oldest queued outcome
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_outcomes.size() == 0) begin
				$display("%0t: result with no request waiting: reject %0d matched %0d",
					$time, reject, matched);
				$display("%0t: slot %0d status %0d", $time, slot, status);
				error_count++;
			end else begin
				head_outcome = awaited_outcomes.pop_front();
				if (reject !== head_outcome.reject) begin
					$display("%0t: reject expected %0d, got %0d", $time, head_outcome.reject, reject);
					error_count++;
				end
				if (matched !== head_outcome.matched) begin
					$display("%0t: matched expected %0d, got %0d", $time, head_outcome.matched,
						matched);
					error_count++;
				end
				if (slot !== head_outcome.slot) begin
					$display("%0t: slot expected %0d, got %0d", $time, head_outcome.slot, slot);
					error_count++;
				end
				if (status !== head_outcome.status) begin
					$display("%0t: status expected %0d, got %0d", $time, head_outcome.status,
						status);
					error_count++;
				end
			end
		end
	end

	// Stop the run when no request, result or register write moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: nothing accepted for %0d cycles", $time, idle_cycles);
			$display("Verification failed");
			$finish;
		end
	end

endmodule
